/* hdl/gddu_pkg.sv */
// ---------------------------------------------------------------------------
// gddu_pkg
// Shared types and constants for the Gregorian day difference unit.
// ---------------------------------------------------------------------------
package gddu_pkg;

	localparam int YEAR_W      = 14;
	localparam int MONTH_W     = 4;
	localparam int DAY_W       = 5;
	localparam int COUNT_W     = 22;
	localparam int WDAY_W      = 3;
	localparam int DN_W        = 23;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	// reciprocal of 100, exact for operands below 2^15
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 14'd1601;
	localparam logic [MONTH_W-1:0] EPOCH_MONTH = 4'd1;
	localparam logic [DAY_W-1:0]   EPOCH_DAY   = 5'd1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic {
		OP_DAYS    = 1'b0,
		OP_WEEKDAY = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		opcode_t op;
		logic    end_early;
		date_t   start;
		date_t   fin;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* hdl/gregorian_day_difference_unit.sv */
// ---------------------------------------------------------------------------
// gregorian_day_difference_unit
// Day count between two Gregorian dates, or weekday of the end date.
// ---------------------------------------------------------------------------
// channel  dir  signals                    word
// s_       in   tvalid tready tdata tuser  two dates, opcode in tuser
// m_       out  tvalid tready tdata        day count, order flag, weekday
//
// one word per cycle sustained while m_tready keeps up; from accept to m_tvalid a word
// passes the input register, the queue write, four compute stages, then the output register
// the compute pipeline advances whenever the output register is free or taken
// the queue absorbs output stalls so the input side keeps accepting words until it is full
// reset clears all valid bits and queue pointers, no clearing pass
// ---------------------------------------------------------------------------
module gregorian_day_difference_unit import gddu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // start_year, start_month, start_day,
	                                         // end_year, end_month, end_day
	input  logic                   s_tuser,  // opcode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // day_count, end_before_start, weekday
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	entry_t  push_entry;
	entry_t  pop_entry;

	gddu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	gddu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_stat     (q_stat)
	);

	gddu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_entry (pop_entry),
		.q_stat    (q_stat),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_flag_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[22]) |-> (m_tdata[21:0] == '0 && m_tdata[25:23] == '0))
		else $error("order flag with nonzero count or weekday");

	a_weekday_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[25:23] != '0) |-> (m_tdata[21:0] == '0))
		else $error("weekday and count both set");
`endif

endmodule

/* hdl/gddu_front.sv */
// ---------------------------------------------------------------------------
// gddu_front
// Input stage: takes a word, flags the order of the two dates and pushes the entry.
// ---------------------------------------------------------------------------
module gddu_front import gddu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // start y, m, d, end y, m, d, zero pad
	input  logic                  s_tuser,  // opcode
	input  q_stat_t               q_stat,
	output logic                  push,
	output entry_t                push_entry
);

	date_t   start_in;
	date_t   fin_in;
	date_t   start_eff;
	opcode_t op_in;
	entry_t  entry_s1;
	logic    valid_s1;

	function automatic logic precedes(input date_t a, input date_t b);
		logic r;
		if (a.year != b.year) begin
			r = a.year < b.year;
		end else if (a.month != b.month) begin
			r = a.month < b.month;
		end else begin
			r = a.day < b.day;
		end
		return r;
	endfunction

	assign start_in.year  = s_tdata[13:0];
	assign start_in.month = s_tdata[17:14];
	assign start_in.day   = s_tdata[22:18];
	assign fin_in.year    = s_tdata[36:23];
	assign fin_in.month   = s_tdata[40:37];
	assign fin_in.day     = s_tdata[45:41];
	assign op_in          = opcode_t'(s_tuser);

	// weekday is counted against the epoch date
	always_comb begin
		if (op_in == OP_WEEKDAY) begin
			start_eff.year  = EPOCH_YEAR;
			start_eff.month = EPOCH_MONTH;
			start_eff.day   = EPOCH_DAY;
		end else begin
			start_eff = start_in;
		end
	end

	assign push       = valid_s1 && !q_stat.full;
	assign s_tready   = !valid_s1 || !q_stat.full;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			entry_s1.op        <= op_in;
			entry_s1.end_early <= precedes(fin_in, start_eff);
			entry_s1.start     <= start_eff;
			entry_s1.fin       <= fin_in;
		end
	end

endmodule

/* hdl/gddu_queue.sv */
// ---------------------------------------------------------------------------
// gddu_queue
// Short first-in first-out queue between the input and compute stages.
// ---------------------------------------------------------------------------
module gddu_queue import gddu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  push_entry,
	input  logic    pop,
	output entry_t  pop_entry,
	output q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = count_q == CNT_W'(DEPTH);
	assign q_stat.empty = count_q == '0;
	assign pop_entry    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hdl/gddu_back.sv */
// ---------------------------------------------------------------------------
// gddu_back
// Compute pipeline: day numbers of both dates, difference, count or weekday.
// ---------------------------------------------------------------------------
module gddu_back import gddu_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  entry_t                 pop_entry,
	input  q_stat_t                q_stat,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata  // day_count, end_before_start, weekday, zero pad
);

	localparam int YP_W = YEAR_W + 1;
	localparam int QA_W = 8;
	localparam int QB_W = 6;
	localparam int Q4_W = YP_W - 2;
	localparam int PA_W = YP_W + 13;
	localparam int PB_W = Q4_W + 13;
	localparam int PY_W = YEAR_W + 13;
	localparam int PRE_W = 9;
	localparam int DF_W = DN_W + 1;

	typedef struct packed {
		date_t             dt;
		logic [DN_W-1:0]   y365;
		logic [Q4_W-1:0]   q4;
		logic [QA_W-1:0]   qa;
		logic [QB_W-1:0]   qb;
		logic [QA_W-1:0]   qy;
	} yparts_t;

	typedef struct packed {
		logic [DN_W-1:0]  whole;
		logic [PRE_W-1:0] pre;
		logic [DAY_W-1:0] day;
	} dparts_t;

	function automatic logic [PRE_W-1:0] month_prefix(input logic [MONTH_W-1:0] m);
		logic [PRE_W-1:0] p;
		case (m)
			4'd0, 4'd1: p = 9'd0;
			4'd2:       p = 9'd31;
			4'd3:       p = 9'd59;
			4'd4:       p = 9'd90;
			4'd5:       p = 9'd120;
			4'd6:       p = 9'd151;
			4'd7:       p = 9'd181;
			4'd8:       p = 9'd212;
			4'd9:       p = 9'd243;
			4'd10:      p = 9'd273;
			4'd11:      p = 9'd304;
			4'd12:      p = 9'd334;
			default:    p = 9'd365;
		endcase
		return p;
	endfunction

	// 2^3 = 1 mod 7, so octal digits fold
	function automatic logic [2:0] mod7(input logic [DF_W-1:0] v);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		s1 = '0;
		for (int k = 0; k < DF_W / 3; k++) begin
			s1 = s1 + 6'(v[3*k +: 3]);
		end
		s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
		s3 = s2[2:0] + 3'(s2[3]);
		return (s3 == 3'd7) ? 3'd0 : s3;
	endfunction

	logic    ce;
	logic    v_s1, v_s2, v_s3, v_s4;
	opcode_t op_s1, op_s2, op_s3, op_s4;
	logic    bf_s1, bf_s2, bf_s3, bf_s4;
	yparts_t yp_s1 [2];
	dparts_t dp_s2 [2];
	logic [DN_W-1:0] dn_s3 [2];
	logic signed [DF_W-1:0] diff_s4;

	yparts_t yp_c [2];
	dparts_t dp_c [2];
	date_t   dates [2];

	logic [COUNT_W-1:0] count_c;
	logic [WDAY_W-1:0]  wday_c;
	logic               valid_q;
	logic [OUT_TDATA_W-1:0] tdata_q;

	assign ce       = !valid_q || m_tready;
	assign pop      = ce && !q_stat.empty;
	assign m_tvalid = valid_q;
	assign m_tdata  = tdata_q;
	assign dates[0] = pop_entry.start;
	assign dates[1] = pop_entry.fin;

	// year parts: y*365, ceil quarters, ceil centuries and four-centuries, floor centuries by reciprocal
	always_comb begin
		logic [YP_W-1:0] ya;
		logic [Q4_W-1:0] yb;
		logic [PA_W-1:0] pa;
		logic [PB_W-1:0] pb;
		logic [PY_W-1:0] py;
		for (int i = 0; i < 2; i++) begin
			ya = YP_W'(dates[i].year) + YP_W'(99);
			yb = Q4_W'((YP_W'(dates[i].year) + YP_W'(399)) >> 2);
			pa = PA_W'(ya) * PA_W'(RECIP_100);
			pb = PB_W'(yb) * PB_W'(RECIP_100);
			py = PY_W'(dates[i].year) * PY_W'(RECIP_100);
			yp_c[i].dt   = dates[i];
			yp_c[i].y365 = DN_W'(dates[i].year) * DN_W'(365);
			yp_c[i].q4   = Q4_W'((YP_W'(dates[i].year) + YP_W'(3)) >> 2);
			yp_c[i].qa   = QA_W'(pa >> RECIP_SHIFT);
			yp_c[i].qb   = QB_W'(pb >> RECIP_SHIFT);
			yp_c[i].qy   = QA_W'(py >> RECIP_SHIFT);
		end
	end

	// leap test, whole-year days and month prefix with leap day
	always_comb begin
		logic [YEAR_W-1:0] rem;
		logic              leap;
		for (int i = 0; i < 2; i++) begin
			rem  = yp_s1[i].dt.year - YEAR_W'(YEAR_W'(yp_s1[i].qy) * YEAR_W'(100));
			leap = (yp_s1[i].dt.year[1:0] == 2'b00)
				&& ((rem != '0) || (yp_s1[i].qy[1:0] == 2'b00));
			dp_c[i].whole = yp_s1[i].y365 + DN_W'(yp_s1[i].q4)
				- DN_W'(yp_s1[i].qa) + DN_W'(yp_s1[i].qb);
			dp_c[i].pre = month_prefix(yp_s1[i].dt.month)
				+ PRE_W'(leap && (yp_s1[i].dt.month > 4'd2));
			dp_c[i].day = yp_s1[i].dt.day;
		end
	end

	always_comb begin
		count_c = '0;
		wday_c  = '0;
		if (op_s4 == OP_DAYS) begin
			if (!bf_s4 && (diff_s4 > 0)) begin
				count_c = (diff_s4 > $signed(DF_W'(COUNT_MAX))) ? COUNT_MAX
					: COUNT_W'(diff_s4);
			end
		end else begin
			if (!bf_s4 && !diff_s4[DF_W-1]) begin
				wday_c = mod7(diff_s4) + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else if (ce) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s1 <= pop_entry.op;
			bf_s1 <= pop_entry.end_early;
			op_s2 <= op_s1;
			bf_s2 <= bf_s1;
			op_s3 <= op_s2;
			bf_s3 <= bf_s2;
			op_s4 <= op_s3;
			bf_s4 <= bf_s3;
			for (int i = 0; i < 2; i++) begin
				yp_s1[i] <= yp_c[i];
				dp_s2[i] <= dp_c[i];
				dn_s3[i] <= dp_s2[i].whole + DN_W'(dp_s2[i].pre) + DN_W'(dp_s2[i].day);
			end
			diff_s4 <= $signed({1'b0, dn_s3[1]}) - $signed({1'b0, dn_s3[0]});
			tdata_q <= {(OUT_TDATA_W - COUNT_W - 1 - WDAY_W)'(0), wday_c, bf_s4 && (op_s4 == OP_DAYS),
				count_c};
		end
	end

endmodule
